// ===== rtl/aeg_pkg.sv =====
// Shared constants for the ADSR envelope gain unit.
// No dependencies; used by adsr_envelope_gain_unit, aeg_checker and tb.
`default_nettype none

package aeg_pkg;

    // Default width of elapsed time and phase lengths.
    localparam int TIME_BITS_DEF = 24;

    // Field widths.
    localparam int CFG_LEN_W = 24;
    localparam int LVL_W     = 17;
    localparam int VEL_W     = 7;
    localparam int GAIN_W    = 17;

    // Full scale in Q1.16.
    localparam logic [LVL_W-1:0] FULL_SCALE = 17'h10000;

    // Register map (index of each register).
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HOLD    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/aeg_div_cell.sv =====
// One cell of the pipelined restoring divider: resolves one quotient bit.
// Depends on nothing outside this file.
`default_nettype none

module aeg_div_cell #(
    parameter int K  = 0,
    parameter int NW = 48,
    parameter int DW = 31,
    parameter int QW = 17
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  wire  [NW-1:0] i_rem,
    input  wire  [DW-1:0] i_div,
    input  wire  [QW-1:0] i_quo,
    output logic          o_valid,
    input  wire           i_ready,
    output logic [NW-1:0] o_rem,
    output logic [DW-1:0] o_div,
    output logic [QW-1:0] o_quo
);

    logic          r_valid;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_quo;
    logic [NW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [NW-1:0] shifted;
    logic          fits;

    // The cell takes a beat when empty or when its own beat moves on.
    assign o_ready = !r_valid || i_ready;

    // Trial subtraction of the divisor aligned to this quotient bit.
    always_comb begin
        shifted = NW'(i_div) << K;
        fits    = (i_rem >= shifted);
        n_rem   = fits ? (i_rem - shifted) : i_rem;
        n_quo   = i_quo | (QW'(fits) << K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem <= n_rem;
            r_div <= i_div;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;

endmodule

`default_nettype wire

// ===== rtl/adsr_envelope_gain_unit.sv =====
// ADSR envelope gain unit: 5 front stages, then 17 divider cells.
// Throughput is one beat per cycle while the output does not stall; every stage and cell holds one beat and
// moves it on when the next place is free, so bubbles close up under stall.
// The division is a row of 17 cells, one quotient bit each.
// Reset (synchronous, active low) empties the pipeline and clears the configuration and boundary registers.
`default_nettype none

module adsr_envelope_gain_unit #(
    parameter int TIME_BITS = aeg_pkg::TIME_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [4:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input channel.
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [TIME_BITS-1:0]         i_elapsed,
    input  wire  [aeg_pkg::VEL_W-1:0]    i_velocity,
    input  wire                          i_releasing,
    // Output channel.
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [aeg_pkg::GAIN_W-1:0]   o_gain
);

    localparam int TW = TIME_BITS;
    localparam int BW = TW + 2;
    localparam int LW = aeg_pkg::LVL_W;
    localparam int VW = aeg_pkg::VEL_W;
    localparam int PW = TW + LW;
    localparam int NW = PW + VW;
    localparam int DW = TW + VW;
    localparam int QW = aeg_pkg::GAIN_W;
    localparam int CW = aeg_pkg::CFG_LEN_W;

    // Configuration registers.
    logic [CW-1:0] r_attack, r_decay, r_hold, r_release;
    logic [LW-1:0] r_sustain;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_hold    <= '0;
            r_release <= '0;
            r_sustain <= '0;
        end else if (wr_en) begin
            case (paddr[4:2])
                aeg_pkg::REG_ATTACK:  r_attack  <= pwdata[CW-1:0];
                aeg_pkg::REG_DECAY:   r_decay   <= pwdata[CW-1:0];
                aeg_pkg::REG_HOLD:    r_hold    <= pwdata[CW-1:0];
                aeg_pkg::REG_RELEASE: r_release <= pwdata[CW-1:0];
                aeg_pkg::REG_SUSTAIN: r_sustain <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            aeg_pkg::REG_ATTACK:  prdata = 32'(r_attack);
            aeg_pkg::REG_DECAY:   prdata = 32'(r_decay);
            aeg_pkg::REG_HOLD:    prdata = 32'(r_hold);
            aeg_pkg::REG_RELEASE: prdata = 32'(r_release);
            aeg_pkg::REG_SUSTAIN: prdata = 32'(r_sustain);
            default:              prdata = '0;
        endcase
    end

    // Lengths at time width, saturated sustain level, phase boundaries.
    logic [TW-1:0] len_a, len_d, len_h, len_r;
    logic [LW-1:0] lvl;
    logic [BW-1:0] r_b1, r_b2, r_b3;

    assign len_a = TW'(r_attack);
    assign len_d = TW'(r_decay);
    assign len_h = TW'(r_hold);
    assign len_r = TW'(r_release);
    assign lvl   = (r_sustain > aeg_pkg::FULL_SCALE) ? aeg_pkg::FULL_SCALE : r_sustain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1 <= '0;
            r_b2 <= '0;
            r_b3 <= '0;
        end else begin
            r_b1 <= BW'(len_a) + BW'(len_d);
            r_b2 <= BW'(len_a) + BW'(len_d) + BW'(len_h);
            r_b3 <= BW'(len_a) + BW'(len_d) + BW'(len_h) + BW'(len_r);
        end
    end

    // Stage ready chain.
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, c0_rdy;
    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    assign s5_rdy  = !r5_v || c0_rdy;
    assign s4_rdy  = !r4_v || s5_rdy;
    assign s3_rdy  = !r3_v || s4_rdy;
    assign s2_rdy  = !r2_v || s3_rdy;
    assign s1_rdy  = !r1_v || s2_rdy;
    assign o_ready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (s1_rdy) r1_v <= i_valid;
            if (s2_rdy) r2_v <= r1_v;
            if (s3_rdy) r3_v <= r2_v;
            if (s4_rdy) r4_v <= r3_v;
            if (s5_rdy) r5_v <= r4_v;
        end
    end

    // Stage 1: register the input beat.
    logic [TW-1:0] r1_t;
    logic [VW-1:0] r1_vel;
    logic          r1_rel;

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r1_t   <= i_elapsed;
            r1_vel <= i_velocity;
            r1_rel <= i_releasing;
        end
    end

    // Phase decode: pick level factor, time span, divisor length and decay base.
    logic [LW-1:0] n2_f;
    logic [TW-1:0] n2_s, n2_x;
    logic [PW-1:0] n2_base;
    logic          n2_sub;
    logic [BW-1:0] tb;

    always_comb begin
        tb      = BW'(r1_t);
        n2_f    = '0;
        n2_s    = '0;
        n2_x    = TW'(1);
        n2_base = '0;
        n2_sub  = 1'b0;
        if (r1_rel) begin
            if (r1_t < len_r) begin
                n2_f = lvl;
                n2_s = len_r - r1_t;
                n2_x = len_r;
            end
        end else if (tb < BW'(len_a)) begin
            n2_f = aeg_pkg::FULL_SCALE;
            n2_s = r1_t;
            n2_x = len_a;
        end else if (tb < r_b1) begin
            n2_f    = aeg_pkg::FULL_SCALE - lvl;
            n2_s    = r1_t - len_a;
            n2_x    = len_d;
            n2_base = PW'(len_d) << 16;
            n2_sub  = 1'b1;
        end else if (tb < r_b2) begin
            n2_f = lvl;
            n2_s = TW'(1);
        end else if (tb < r_b3) begin
            n2_f = lvl;
            n2_s = len_r - TW'(tb - r_b2);
            n2_x = len_r;
        end
    end

    // Stage 2: decoded operands.
    logic [LW-1:0] r2_f;
    logic [TW-1:0] r2_s, r2_x;
    logic [PW-1:0] r2_base;
    logic          r2_sub;
    logic [VW-1:0] r2_vel;

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r2_f    <= n2_f;
            r2_s    <= n2_s;
            r2_x    <= n2_x;
            r2_base <= n2_base;
            r2_sub  <= n2_sub;
            r2_vel  <= r1_vel;
        end
    end

    // Stage 3: level factor times span.
    logic [PW-1:0] r3_p, r3_base;
    logic [TW-1:0] r3_x;
    logic          r3_sub;
    logic [VW-1:0] r3_vel;

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r3_p    <= PW'(r2_f) * PW'(r2_s);
            r3_base <= r2_base;
            r3_x    <= r2_x;
            r3_sub  <= r2_sub;
            r3_vel  <= r2_vel;
        end
    end

    // Stage 4: in decay the numerator is the base less the product, else the product.
    logic [PW-1:0] r4_m;
    logic [TW-1:0] r4_x;
    logic [VW-1:0] r4_vel;

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r4_m   <= r3_sub ? (r3_base - r3_p) : r3_p;
            r4_x   <= r3_x;
            r4_vel <= r3_vel;
        end
    end

    // Stage 5: velocity scaling and divisor 127 times the length.
    logic [NW-1:0] r5_n;
    logic [DW-1:0] r5_div;

    always_ff @(posedge i_clk) begin
        if (s5_rdy) begin
            r5_n   <= NW'(r4_vel) * NW'(r4_m);
            r5_div <= (DW'(r4_x) << VW) - DW'(r4_x);
        end
    end

    // Divider row: cell j resolves quotient bit QW-1-j.
    logic          c_v   [0:QW];
    logic          c_rdy [0:QW];
    logic [NW-1:0] c_rem [0:QW];
    logic [DW-1:0] c_div [0:QW];
    logic [QW-1:0] c_quo [0:QW];

    assign c_v[0]   = r5_v;
    assign c_rem[0] = r5_n;
    assign c_div[0] = r5_div;
    assign c_quo[0] = '0;
    assign c0_rdy   = c_rdy[0];
    assign c_rdy[QW] = i_ready;

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_cell
            aeg_div_cell #(
                .K  (QW - 1 - j),
                .NW (NW),
                .DW (DW),
                .QW (QW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (c_v[j]),
                .o_ready (c_rdy[j]),
                .i_rem   (c_rem[j]),
                .i_div   (c_div[j]),
                .i_quo   (c_quo[j]),
                .o_valid (c_v[j+1]),
                .i_ready (c_rdy[j+1]),
                .o_rem   (c_rem[j+1]),
                .o_div   (c_div[j+1]),
                .o_quo   (c_quo[j+1])
            );
        end
    endgenerate

    assign o_valid = c_v[QW];
    assign o_gain  = c_quo[QW];

    // Checks.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gain <= aeg_pkg::FULL_SCALE))
        else $error("gain above full scale");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (c_rem[QW] < NW'(c_div[QW])))
        else $error("divider remainder not below divisor");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== tb/sv/aeg_checker.sv =====
// Checker for the ADSR envelope gain unit: mirrors the register file from the
// configuration port, predicts the gain of every input beat and compares it.
// Depends on aeg_pkg for field widths and the register map.
module aeg_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire                              pready,
    input  wire  [4:0]                       paddr,
    input  wire  [31:0]                      pwdata,
    input  wire                              in_valid,
    input  wire                              in_ready,
    input  wire  [aeg_pkg::CFG_LEN_W-1:0]    elapsed,
    input  wire  [aeg_pkg::VEL_W-1:0]        velocity,
    input  wire                              releasing,
    input  wire                              out_valid,
    input  wire                              out_ready,
    input  wire  [aeg_pkg::GAIN_W-1:0]       gain,
    output int                               fail_count,
    output int                               pending_gains
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [aeg_pkg::CFG_LEN_W-1:0] attack_q, decay_q, hold_q, release_q;
    logic [aeg_pkg::LVL_W-1:0]     sustain_q;
    logic [aeg_pkg::GAIN_W-1:0]    gain_queue[$];

    assign pending_gains = gain_queue.size();

    // Envelope gain at one sample offset, with the same truncating quotients.
    function automatic logic [aeg_pkg::GAIN_W-1:0] envelope_gain(
        input logic [aeg_pkg::CFG_LEN_W-1:0] t_in, input logic [aeg_pkg::VEL_W-1:0] v_in,
        input logic rel_in);
        longint unsigned t, v, a, d, h, r, l, g;
        t = t_in; v = v_in; a = attack_q; d = decay_q; h = hold_q; r = release_q;
        l = (sustain_q > aeg_pkg::FULL_SCALE) ? aeg_pkg::FULL_SCALE : sustain_q;
        g = 0;
        if (rel_in) begin
            if (t < r) g = (v * l * (r - t)) / (127 * r);
        end else if (t < a) begin
            g = (v * 65536 * t) / (127 * a);
        end else if (t < a + d) begin
            g = (v * (65536 * d - (65536 - l) * (t - a))) / (127 * d);
        end else if (t < a + d + h) begin
            g = (v * l) / 127;
        end else if (t < a + d + h + r) begin
            g = (v * l * (r - (t - a - d - h))) / (127 * r);
        end
        return g[aeg_pkg::GAIN_W-1:0];
    endfunction

    // Register mirror, prediction on input beats, comparison on output beats.
    always @(posedge i_clk) begin
        logic [aeg_pkg::GAIN_W-1:0] want;
        if (!i_rst_n) begin
            attack_q <= '0; decay_q <= '0; hold_q <= '0; release_q <= '0;
            sustain_q <= '0;
            fail_count <= 0;
            gain_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    aeg_pkg::REG_ATTACK:  attack_q  <= pwdata[aeg_pkg::CFG_LEN_W-1:0];
                    aeg_pkg::REG_DECAY:   decay_q   <= pwdata[aeg_pkg::CFG_LEN_W-1:0];
                    aeg_pkg::REG_HOLD:    hold_q    <= pwdata[aeg_pkg::CFG_LEN_W-1:0];
                    aeg_pkg::REG_RELEASE: release_q <= pwdata[aeg_pkg::CFG_LEN_W-1:0];
                    aeg_pkg::REG_SUSTAIN: sustain_q <= pwdata[aeg_pkg::LVL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                gain_queue.push_back(envelope_gain(elapsed, velocity, releasing));
            if (out_valid && out_ready) begin
                if (gain_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected gain beat: %0d", gain);
                    fail_count <= fail_count + 1;
                end else begin
                    want = gain_queue.pop_front();
                    if (want !== gain) begin
                        if (fail_count < 10)
                            $display("gain mismatch: expected %0d, got %0d", want, gain);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the ADSR envelope gain testbench: clock, reset, configuration
// phases, input stimulus with random gaps and output back-pressure.
// Depends on aeg_pkg, adsr_envelope_gain_unit and aeg_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 22;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                          i_clk, i_rst_n;
    logic                          psel, penable, pwrite, pready;
    logic [4:0]                    paddr;
    logic [31:0]                   pwdata, prdata;
    logic                          in_valid, in_ready, out_valid, out_ready;
    logic [aeg_pkg::CFG_LEN_W-1:0] elapsed;
    logic [aeg_pkg::VEL_W-1:0]     velocity;
    logic                          releasing;
    logic [aeg_pkg::GAIN_W-1:0]    gain;
    int                            fail_count, pending_gains;
    int                            idle_cycles;
    bit                            hold_off_req, hold_off_done;
    logic [aeg_pkg::CFG_LEN_W-1:0] cur_attack, cur_decay, cur_hold, cur_release;

    adsr_envelope_gain_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(in_valid), .o_ready(in_ready), .i_elapsed(elapsed),
        .i_velocity(velocity), .i_releasing(releasing),
        .o_valid(out_valid), .i_ready(out_ready), .o_gain(gain)
    );

    aeg_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready), .elapsed(elapsed),
        .velocity(velocity), .releasing(releasing),
        .out_valid(out_valid), .out_ready(out_ready), .gain(gain),
        .fail_count(fail_count), .pending_gains(pending_gains)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        out_ready = 1'b0;
        hold_off_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog on cycles without any accepted beat or bus access.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One register write; the bus is released by the caller after the last one.
    task automatic reg_write(input logic [aeg_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            aeg_pkg::REG_ATTACK:  cur_attack  = value[aeg_pkg::CFG_LEN_W-1:0];
            aeg_pkg::REG_DECAY:   cur_decay   = value[aeg_pkg::CFG_LEN_W-1:0];
            aeg_pkg::REG_HOLD:    cur_hold    = value[aeg_pkg::CFG_LEN_W-1:0];
            aeg_pkg::REG_RELEASE: cur_release = value[aeg_pkg::CFG_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_envelope(input logic [31:0] a, input logic [31:0] d,
                                 input logic [31:0] h, input logic [31:0] r,
                                 input logic [31:0] lvl);
        reg_write(aeg_pkg::REG_ATTACK, a);
        reg_write(aeg_pkg::REG_DECAY, d);
        reg_write(aeg_pkg::REG_HOLD, h);
        reg_write(aeg_pkg::REG_RELEASE, r);
        reg_write(aeg_pkg::REG_SUSTAIN, lvl);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // One input beat, with a random gap before it; valid stays up for the next beat.
    task automatic send_beat(input logic [aeg_pkg::CFG_LEN_W-1:0] t,
                             input logic [aeg_pkg::VEL_W-1:0] v, input logic rel);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        elapsed <= t; velocity <= v; releasing <= rel;
        @(posedge i_clk iff in_ready);
    endtask

    // Elapsed time biased toward the phase boundaries of the envelope.
    function automatic logic [aeg_pkg::CFG_LEN_W-1:0] pick_elapsed();
        longint unsigned edge_pt, sum3;
        logic [31:0]     raw;
        sum3 = cur_attack + cur_decay + cur_hold;
        case ($urandom_range(0, 6))
            0: edge_pt = cur_attack;
            1: edge_pt = cur_attack + cur_decay;
            2: edge_pt = sum3;
            3: edge_pt = sum3 + cur_release;
            4: edge_pt = cur_release;
            5: begin
                raw = $urandom();
                return raw[aeg_pkg::CFG_LEN_W-1:0];
            end
            default: edge_pt = $urandom_range(0, sum3 + cur_release + 4);
        endcase
        edge_pt = edge_pt + $urandom_range(0, 4) - 2;
        if (edge_pt > 24'hFFFFFF) edge_pt = 24'hFFFFFF;
        return edge_pt[aeg_pkg::CFG_LEN_W-1:0];
    endfunction

    // Stop offering beats and wait until every predicted gain has come out.
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_gains == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        logic [aeg_pkg::VEL_W-1:0] v;
        repeat (count) begin
            v = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom_range(0, 127));
            send_beat(pick_elapsed(), v, 1'($urandom_range(0, 3) == 0));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; elapsed = '0; velocity = '0; releasing = 1'b0;
        hold_off_req = 1'b0;
        cur_attack = '0; cur_decay = '0; cur_hold = '0; cur_release = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: every phase has zero length, so the gain is zero.
        send_beat(24'd5, 7'd127, 1'b0);
        send_beat(24'd0, 7'd127, 1'b1);
        drain();

        // Directed: small envelope, walk through every phase and its edges.
        load_envelope(32'd10, 32'd10, 32'd10, 32'd10, 32'd32768);
        send_beat(24'd0, 7'd127, 1'b0);
        send_beat(24'd9, 7'd127, 1'b0);
        send_beat(24'd10, 7'd127, 1'b0);
        send_beat(24'd19, 7'd64, 1'b0);
        send_beat(24'd20, 7'd127, 1'b0);
        send_beat(24'd29, 7'd1, 1'b0);
        send_beat(24'd30, 7'd127, 1'b0);
        send_beat(24'd39, 7'd127, 1'b0);
        send_beat(24'd40, 7'd127, 1'b0);
        send_beat(24'd0, 7'd127, 1'b1);
        send_beat(24'd9, 7'd127, 1'b1);
        send_beat(24'd10, 7'd127, 1'b1);
        send_beat(24'hFFFFFF, 7'd0, 1'b0);
        drain();

        // Directed: maximum lengths, saturating sustain level, zero release.
        load_envelope(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'd0, 32'h1FFFF);
        send_beat(24'hFFFFFF, 7'd127, 1'b0);
        send_beat(24'hFFFFFE, 7'd127, 1'b0);
        send_beat(24'd1, 7'd127, 1'b0);
        send_beat(24'd0, 7'd127, 1'b1);
        send_beat(24'h800000, 7'd127, 1'b1);
        drain();

        load_envelope(32'd0, 32'd0, 32'd0, 32'hFFFFFF, 32'd65536);
        send_beat(24'd0, 7'd127, 1'b0);
        send_beat(24'hFFFFFF, 7'd127, 1'b1);
        send_beat(24'd0, 7'd127, 1'b1);
        drain();

        // Random: several envelopes, one with the receiver held off.
        for (int phase = 0; phase < 12; phase++) begin
            if (phase % 4 == 3)
                load_envelope($urandom() & 32'hFFFFFF, $urandom() & 32'hFFFFFF,
                              $urandom() & 32'hFFFFFF, $urandom() & 32'hFFFFFF,
                              $urandom_range(0, 131071));
            else
                load_envelope($urandom_range(0, 300), $urandom_range(0, 300),
                              $urandom_range(0, 300), $urandom_range(0, 300),
                              $urandom_range(0, 65536));
            if (phase == 5) hold_off_req = 1'b1;
            random_phase(95);
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
